// ===== sv/bmhq_pkg.sv =====
// shared types and codes for the binary max-heap queue
package bmhq_pkg;

    localparam logic [1:0] KIND_ENQ = 2'd0;
    localparam logic [1:0] KIND_DEQ = 2'd1;
    localparam logic [1:0] KIND_INC = 2'd2;
    localparam logic [1:0] KIND_DEC = 2'd3;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_FULL     = 3'd1;
    localparam logic [2:0] ST_EMPTY    = 3'd2;
    localparam logic [2:0] ST_NOTFOUND = 3'd3;
    localparam logic [2:0] ST_NOCHANGE = 3'd4;

    localparam int TAG_W = 16;
    localparam int PRI_W = 32;
    localparam int ENT_W = TAG_W + PRI_W;

    typedef struct packed {
        logic [TAG_W-1:0]        tag;
        logic signed [PRI_W-1:0] pri;
    } entry_t;

    // datapath operations issued by the controller
    localparam logic [3:0] OP_NONE     = 4'd0;
    localparam logic [3:0] OP_LOAD     = 4'd1;  // latch request
    localparam logic [3:0] OP_RD_A     = 4'd2;  // read addr a into slot a
    localparam logic [3:0] OP_RD_B     = 4'd3;  // read addr b into slot b
    localparam logic [3:0] OP_WR_X     = 4'd4;  // write held entry x at idx
    localparam logic [3:0] OP_WR_A     = 4'd5;  // write slot a at idx
    localparam logic [3:0] OP_SET_IDX  = 4'd6;  // idx <= addr a (par or child)
    localparam logic [3:0] OP_CAP_ROOT = 4'd7;  // keep slot a as dequeued root
    localparam logic [3:0] OP_X_FROM_A = 4'd8;  // x <= slot a
    localparam logic [3:0] OP_SCAN     = 4'd9;  // idx++
    localparam logic [3:0] OP_CNT_INC  = 4'd10;
    localparam logic [3:0] OP_CNT_DEC  = 4'd11;
    localparam logic [3:0] OP_X_PRI    = 4'd12; // x.pri <= request priority
    localparam logic [3:0] OP_CLR_IDX  = 4'd13;
    localparam logic [3:0] OP_CHILD_B  = 4'd14; // slot a <= slot b, addr a <= b

    // address selects
    localparam logic [2:0] AD_IDX   = 3'd0;
    localparam logic [2:0] AD_PAR   = 3'd1;
    localparam logic [2:0] AD_LEFT  = 3'd2;
    localparam logic [2:0] AD_RIGHT = 3'd3;
    localparam logic [2:0] AD_LAST  = 3'd4;
    localparam logic [2:0] AD_ZERO  = 3'd5;

    typedef struct packed {
        logic [3:0] op;
        logic [2:0] addr_sel;
    } dp_cmd_t;

    typedef struct packed {
        logic [1:0] kind;
        logic       full;        // count at or above limit
        logic       cnt_zero;
        logic       idx_zero;
        logic       idx_at_cnt;  // scan reached count
        logic       tag_hit;     // slot a tag equals request tag
        logic       par_lt_x;    // slot a pri < x pri
        logic       left_ok;     // left child index < count
        logic       right_ok;
        logic       b_gt_a;      // slot b pri > slot a pri
        logic       x_gt_a;      // x pri > slot a pri
        logic       req_gt_a;    // request pri > slot a pri
        logic       req_lt_a;
    } dp_stat_t;

endpackage

// ===== sv/bmhq_ram.sv =====
// generic single-port ram with registered read
module bmhq_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

// ===== sv/bmhq_datapath.sv =====
// heap datapath: request latch, index registers, entry slots, heap ram
module bmhq_datapath #(
    parameter int CAPACITY = 64
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  bmhq_pkg::dp_cmd_t    cmd,
    input  logic [1:0]           req_kind,
    input  logic [15:0]          req_tag,
    input  logic [31:0]          req_pri,
    input  logic [6:0]           limit,
    output bmhq_pkg::dp_stat_t   stat,
    output logic [15:0]          root_tag,
    output logic [31:0]          root_pri,
    output logic [$clog2(CAPACITY+1)-1:0] count
);
    import bmhq_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int LW = (CW > 7) ? CW : 7;

    logic [1:0]  kind_reg;
    logic [15:0] tag_reg;
    logic [31:0] pri_reg;
    entry_t      x_reg, a_reg, b_reg, root_reg;
    logic [CW-1:0] cnt_reg, idx_reg;
    logic [CW-1:0] aaddr_reg, baddr_reg;
    logic [3:0]  pend_reg;      // read op issued last cycle
    logic [CW-1:0] paddr_reg;

    logic [CW:0]   left_w, right_w;
    logic [CW-1:0] par_w, addr_w;
    logic [LW-1:0] lim_w;
    logic          we;
    entry_t        wdata, rdata;

    assign left_w  = {idx_reg, 1'b1};
    assign right_w = {idx_reg, 1'b0} + (CW+1)'(2);
    assign par_w   = (idx_reg - CW'(1)) >> 1;
    assign lim_w   = (LW'(limit) < LW'(CAPACITY)) ? LW'(limit) : LW'(CAPACITY);

    always_comb
    begin
        unique case (cmd.addr_sel)
            AD_IDX:   addr_w = idx_reg;
            AD_PAR:   addr_w = par_w;
            AD_LEFT:  addr_w = left_w[CW-1:0];
            AD_RIGHT: addr_w = right_w[CW-1:0];
            AD_LAST:  addr_w = cnt_reg - CW'(1);
            default:  addr_w = '0;
        endcase
    end

    assign we    = (cmd.op == OP_WR_X) || (cmd.op == OP_WR_A);
    assign wdata = (cmd.op == OP_WR_X) ? x_reg : a_reg;

    bmhq_ram #(.WIDTH(ENT_W), .DEPTH(CAPACITY)) u_ram (
        .clk   (clk),
        .we    (we),
        .addr  (addr_w[AW-1:0]),
        .wdata (wdata),
        .rdata (rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            pend_reg <= OP_NONE;
        end
        else
        begin
            pend_reg <= cmd.op;
            if (cmd.op == OP_CNT_INC)
            begin
                cnt_reg <= cnt_reg + CW'(1);
            end
            else if (cmd.op == OP_CNT_DEC)
            begin
                cnt_reg <= cnt_reg - CW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        paddr_reg <= addr_w;
        if (pend_reg == OP_RD_A)
        begin
            a_reg     <= rdata;
            aaddr_reg <= paddr_reg;
        end
        if (pend_reg == OP_RD_B)
        begin
            b_reg     <= rdata;
            baddr_reg <= paddr_reg;
        end
        unique case (cmd.op)
            OP_LOAD:
            begin
                kind_reg  <= req_kind;
                tag_reg   <= req_tag;
                pri_reg   <= req_pri;
                x_reg.tag <= req_tag;
                x_reg.pri <= req_pri;
                idx_reg   <= cnt_reg;
            end
            OP_SET_IDX:  idx_reg  <= aaddr_reg;
            OP_CAP_ROOT: root_reg <= a_reg;
            OP_X_FROM_A: x_reg    <= a_reg;
            OP_SCAN:     idx_reg  <= idx_reg + CW'(1);
            OP_X_PRI:    x_reg.pri <= pri_reg;
            OP_CLR_IDX:  idx_reg  <= '0;
            OP_CHILD_B:
            begin
                a_reg     <= b_reg;
                aaddr_reg <= baddr_reg;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        stat.kind       = kind_reg;
        stat.full       = LW'(cnt_reg) >= lim_w;
        stat.cnt_zero   = (cnt_reg == '0);
        stat.idx_zero   = (idx_reg == '0);
        stat.idx_at_cnt = (idx_reg == cnt_reg);
        stat.tag_hit    = (a_reg.tag == tag_reg);
        stat.par_lt_x   = (a_reg.pri < x_reg.pri);
        stat.left_ok    = (left_w < (CW+1)'(cnt_reg));
        stat.right_ok   = (right_w < (CW+1)'(cnt_reg));
        stat.b_gt_a     = (b_reg.pri > a_reg.pri);
        stat.x_gt_a     = (x_reg.pri > a_reg.pri);
        stat.req_gt_a   = ($signed(pri_reg) > a_reg.pri);
        stat.req_lt_a   = ($signed(pri_reg) < a_reg.pri);
    end

    assign root_tag = root_reg.tag;
    assign root_pri = root_reg.pri;
    assign count    = cnt_reg;

endmodule

// ===== sv/bmhq_ctrl.sv =====
// heap controller: sequences enqueue, dequeue, search and sift steps
module bmhq_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_beat,
    input  logic               out_taken,
    input  bmhq_pkg::dp_stat_t stat,
    output bmhq_pkg::dp_cmd_t  cmd,
    output logic               busy,
    output logic               done,
    output logic [2:0]         status,
    output logic               root_valid
);
    import bmhq_pkg::*;

    localparam logic [4:0] S_IDLE   = 5'd0;
    localparam logic [4:0] S_DISP   = 5'd1;
    localparam logic [4:0] S_UP_RD  = 5'd2;
    localparam logic [4:0] S_UP_W1  = 5'd3;
    localparam logic [4:0] S_UP_CMP = 5'd4;
    localparam logic [4:0] S_UP_MV  = 5'd5;
    localparam logic [4:0] S_FIN_X  = 5'd6;
    localparam logic [4:0] S_DQ_W1  = 5'd7;
    localparam logic [4:0] S_DQ_ROOT= 5'd8;
    localparam logic [4:0] S_DQ_W2  = 5'd9;
    localparam logic [4:0] S_DQ_LST = 5'd10;
    localparam logic [4:0] S_DN_RL  = 5'd11;
    localparam logic [4:0] S_DN_RR  = 5'd12;
    localparam logic [4:0] S_DN_W   = 5'd13;
    localparam logic [4:0] S_DN_CMP = 5'd14;
    localparam logic [4:0] S_SC_RD  = 5'd15;
    localparam logic [4:0] S_SC_W   = 5'd16;
    localparam logic [4:0] S_SC_CMP = 5'd17;
    localparam logic [4:0] S_DONE   = 5'd18;
    localparam logic [4:0] S_DN_W2  = 5'd19;
    localparam logic [4:0] S_DN_SEL = 5'd20;
    localparam logic [4:0] S_DN_MV  = 5'd21;

    logic [4:0] state_reg, state_next;
    logic [2:0] st_reg, st_next;
    logic       rv_reg, rv_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            st_reg    <= ST_OK;
            rv_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            st_reg    <= st_next;
            rv_reg    <= rv_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        st_next      = st_reg;
        rv_next      = rv_reg;
        cmd.op       = OP_NONE;
        cmd.addr_sel = AD_IDX;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_beat)
                begin
                    cmd.op     = OP_LOAD;
                    st_next    = ST_OK;
                    rv_next    = 1'b0;
                    state_next = S_DISP;
                end
            end
            S_DISP:
            begin
                unique case (stat.kind)
                    KIND_ENQ:
                    begin
                        if (stat.full)
                        begin
                            st_next    = ST_FULL;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            cmd.op     = OP_CNT_INC;
                            state_next = S_UP_RD;
                        end
                    end
                    KIND_DEQ:
                    begin
                        if (stat.cnt_zero)
                        begin
                            st_next    = ST_EMPTY;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            cmd.op       = OP_RD_A;
                            cmd.addr_sel = AD_ZERO;
                            state_next   = S_DQ_W1;
                        end
                    end
                    default:
                    begin
                        cmd.op     = OP_CLR_IDX;
                        state_next = S_SC_RD;
                    end
                endcase
            end
            // sift up: x holds moving entry, idx its slot
            S_UP_RD:
            begin
                if (stat.idx_zero)
                begin
                    state_next = S_FIN_X;
                end
                else
                begin
                    cmd.op       = OP_RD_A;
                    cmd.addr_sel = AD_PAR;
                    state_next   = S_UP_W1;
                end
            end
            S_UP_W1:  state_next = S_UP_CMP;
            S_UP_CMP:
            begin
                if (stat.par_lt_x)
                begin
                    cmd.op     = OP_WR_A;
                    state_next = S_UP_MV;
                end
                else
                begin
                    state_next = S_FIN_X;
                end
            end
            S_UP_MV:
            begin
                cmd.op     = OP_SET_IDX;
                state_next = S_UP_RD;
            end
            S_FIN_X:
            begin
                cmd.op     = OP_WR_X;
                state_next = S_DONE;
            end
            // dequeue
            S_DQ_W1:
            begin
                cmd.op     = OP_CLR_IDX;
                state_next = S_DQ_ROOT;
            end
            S_DQ_ROOT:
            begin
                cmd.op       = OP_CAP_ROOT;
                rv_next      = 1'b1;
                state_next   = S_DQ_W2;
            end
            S_DQ_W2:
            begin
                cmd.op       = OP_RD_A;
                cmd.addr_sel = AD_LAST;
                state_next   = S_DQ_LST;
            end
            S_DQ_LST:
            begin
                cmd.op     = OP_CNT_DEC;
                state_next = S_DN_W2;
            end
            S_DN_W2:
            begin
                cmd.op     = OP_X_FROM_A;
                state_next = S_DN_RL;
            end
            // sift down: x holds moving entry, idx its slot (set to 0 by clr on dequeue)
            S_DN_RL:
            begin
                if (!stat.left_ok)
                begin
                    state_next = S_FIN_X;
                end
                else
                begin
                    cmd.op       = OP_RD_A;
                    cmd.addr_sel = AD_LEFT;
                    state_next   = S_DN_RR;
                end
            end
            S_DN_RR:
            begin
                if (stat.right_ok)
                begin
                    cmd.op       = OP_RD_B;
                    cmd.addr_sel = AD_RIGHT;
                end
                state_next = S_DN_W;
            end
            S_DN_W:   state_next = S_DN_SEL;
            S_DN_SEL:
            begin
                if (stat.right_ok && stat.b_gt_a)
                begin
                    cmd.op = OP_CHILD_B;
                end
                state_next = S_DN_CMP;
            end
            S_DN_CMP:
            begin
                if (stat.x_gt_a)
                begin
                    state_next = S_FIN_X;
                end
                else
                begin
                    cmd.op     = OP_WR_A;
                    state_next = S_DN_MV;
                end
            end
            S_DN_MV:
            begin
                cmd.op     = OP_SET_IDX;
                state_next = S_DN_RL;
            end
            // linear tag search
            S_SC_RD:
            begin
                if (stat.idx_at_cnt)
                begin
                    st_next    = ST_NOTFOUND;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.op     = OP_RD_A;
                    state_next = S_SC_W;
                end
            end
            S_SC_W:   state_next = S_SC_CMP;
            S_SC_CMP:
            begin
                if (!stat.tag_hit)
                begin
                    cmd.op     = OP_SCAN;
                    state_next = S_SC_RD;
                end
                else if (stat.kind == KIND_INC)
                begin
                    if (stat.req_gt_a)
                    begin
                        cmd.op     = OP_X_PRI;
                        state_next = S_UP_RD;
                    end
                    else
                    begin
                        st_next    = ST_NOCHANGE;
                        state_next = S_DONE;
                    end
                end
                else
                begin
                    if (stat.req_lt_a)
                    begin
                        cmd.op     = OP_X_PRI;
                        state_next = S_DN_RL;
                    end
                    else
                    begin
                        st_next    = ST_NOCHANGE;
                        state_next = S_DONE;
                    end
                end
            end
            S_DONE:
            begin
                if (out_taken)
                begin
                    state_next = S_IDLE;
                end
            end
            default:  state_next = S_IDLE;
        endcase
    end

    assign busy       = (state_reg != S_IDLE);
    assign done       = (state_reg == S_DONE);
    assign status     = st_reg;
    assign root_valid = rv_reg;

    a_done_status: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (st_reg == ST_OK || st_reg == ST_FULL || st_reg == ST_EMPTY
                  || st_reg == ST_NOTFOUND || st_reg == ST_NOCHANGE))
        else $error("bad status");
    a_root_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (done && rv_reg) |-> (st_reg == ST_OK && stat.kind == KIND_DEQ))
        else $error("root flagged on non-dequeue");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !out_taken) |=> done)
        else $error("result dropped");

endmodule

// ===== sv/binary_max_heap_queue_core.sv =====
// top level of the binary max-heap priority queue
//  channel | dir | handshake              | payload
//  s_axis  | in  | s_axis_tvalid/tready   | tdata: tag, priority_req; tuser: kind
//  m_axis  | out | m_axis_tvalid/tready   | tdata: status..is_empty
//  cfg     | in  | cfg_valid/cfg_ready    | cfg_data: capacity_limit
// one item at a time: enqueue/key change walk the heap level by level,
// key changes first search the entries one by one (one ram port)
// dequeue sifts down level by level; all walks share the single heap ram port
// reset empties the queue and sets the limit to 64; ram contents not cleared
// a result waiting on m_axis_tready holds the block
module binary_max_heap_queue_core #(
    parameter int CAPACITY = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // tag[15:0], priority_req[47:16]
    input  logic [1:0]  s_axis_tuser,   // kind
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // status, out_tag, out_priority, entry_count, is_empty
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [6:0]  cfg_data        // capacity_limit
);
    import bmhq_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);

    logic [6:0]  limit_reg;
    dp_cmd_t     cmd;
    dp_stat_t    stat;
    logic        busy, done, root_valid;
    logic [2:0]  status;
    logic [15:0] root_tag;
    logic [31:0] root_pri;
    logic [CW-1:0] count;
    logic [6:0]  cnt7;
    logic        in_beat;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= 7'd64;
        end
        else if (cfg_valid)
        begin
            limit_reg <= cfg_data;
        end
    end

    assign s_axis_tready = !busy;
    assign in_beat       = s_axis_tvalid && !busy;

    bmhq_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_beat    (in_beat),
        .out_taken  (m_axis_tready),
        .stat       (stat),
        .cmd        (cmd),
        .busy       (busy),
        .done       (done),
        .status     (status),
        .root_valid (root_valid)
    );

    bmhq_datapath #(.CAPACITY(CAPACITY)) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .req_kind (s_axis_tuser),
        .req_tag  (s_axis_tdata[15:0]),
        .req_pri  (s_axis_tdata[47:16]),
        .limit    (limit_reg),
        .stat     (stat),
        .root_tag (root_tag),
        .root_pri (root_pri),
        .count    (count)
    );

    assign cnt7 = 7'(count);
    assign m_axis_tvalid = done;
    assign m_axis_tdata  = {5'd0, (count == '0), cnt7,
                            root_valid ? root_pri : 32'd0,
                            root_valid ? root_tag : 16'd0, status};

endmodule
